/* hdl/text_console_engine_unit_macros.svh */
// Assertion macros used by the back stage of the text console engine.
`ifndef TEXT_CONSOLE_ENGINE_UNIT_MACROS_SVH
`define TEXT_CONSOLE_ENGINE_UNIT_MACROS_SVH

// Condition holds in the same cycle.
`define TCE_ASSERT_NOW(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// Condition holds in the following cycle.
`define TCE_ASSERT_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

/* hdl/tce_pkg.sv */
// Package with types, codes and constants of the text console engine.
`timescale 1ns / 1ps
package tce_pkg;

  localparam int DEF_MAX_COLS = 128;
  localparam int DEF_MAX_ROWS = 32;
  localparam int FIFO_DEPTH   = 2;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 8;

  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd1;

  localparam logic [3:0] CMD_PUT_CHAR  = 4'd0;
  localparam logic [3:0] CMD_PUT_CELL  = 4'd1;
  localparam logic [3:0] CMD_SET_CUR   = 4'd2;
  localparam logic [3:0] CMD_CLR_SCR_C = 4'd3;
  localparam logic [3:0] CMD_CLR_SCR_F = 4'd4;
  localparam logic [3:0] CMD_CLR_LN_C  = 4'd5;
  localparam logic [3:0] CMD_CLR_LN_F  = 4'd6;
  localparam logic [3:0] CMD_SCROLL    = 4'd7;
  localparam logic [3:0] CMD_READ      = 4'd8;
  localparam logic [3:0] CMD_NEWLINE   = 4'd9;
  localparam logic [3:0] CMD_SKIP      = 4'd10;

  typedef enum logic [3:0] {
    OP_PUT_CHAR, OP_PUT_CELL, OP_SET_CUR, OP_CLR_SCR, OP_CLR_LINE,
    OP_SCROLL, OP_READ, OP_NEWLINE, OP_SKIP, OP_NOP
  } op_t;

  typedef enum logic [1:0] {WM_COPY, WM_FILL_CHAR, WM_FILL_CELL} walk_mode_t;

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_READ, ST_RESP} back_state_t;

  typedef struct packed {
    op_t               op;
    logic              full;
    logic [7:0]        ch;
    logic [7:0]        attr;
    logic signed [8:0] col;
    logic signed [6:0] row;
    logic signed [6:0] shift;
  } item_t;

endpackage

/* hdl/tce_req_if.sv */
// Request channel interface carrying one console command.
`timescale 1ns / 1ps
interface tce_req_if;
  logic              valid;
  logic              ready;
  logic [3:0]        cmd;
  logic [7:0]        ch;
  logic [7:0]        attr;
  logic signed [8:0] col;
  logic signed [6:0] row;
  logic signed [6:0] shift;
  modport source (output valid, cmd, ch, attr, col, row, shift, input ready);
  modport sink (input valid, cmd, ch, attr, col, row, shift, output ready);
endinterface

/* hdl/tce_rsp_if.sv */
// Response channel interface carrying one cursor report.
`timescale 1ns / 1ps
interface tce_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  cell_char;
  logic [7:0]  cell_attr;
  logic        cell_ok;
  logic [6:0]  cur_col;
  logic [4:0]  cur_row;
  logic [11:0] cur_offset;
  modport source (output valid, cell_char, cell_attr, cell_ok, cur_col, cur_row,
                  cur_offset, input ready);
  modport sink (input valid, cell_char, cell_attr, cell_ok, cur_col, cur_row,
                cur_offset, output ready);
endinterface

/* hdl/text_console_engine_unit.sv */
// Top level of the text console engine: front, queue and back stages.
//
//   channel  direction  transfer carries
//   req      in         cmd, ch, attr, col, row, shift
//   rsp      out        cell_char, cell_attr, cell_ok, cur_col, cur_row, cur_offset
//   cfg      in         register index and write data, no handshake
//
// A clear or a scroll writes its cells one after another through the single memory write port.
// A wrap at the bottom row adds a scroll and a line clear to the command.
// Reset is synchronous and needs no clearing pass; screen cells start undefined.
// A stalled response holds the back stage while the queue takes commands until it is full.
`timescale 1ns / 1ps
module text_console_engine_unit import tce_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  tce_req_if.sink               req,
  tce_rsp_if.source             rsp
);

  logic  push;
  item_t push_item;
  logic  push_ready;
  logic  head_valid;
  item_t head;
  logic  pop;

  tce_front u_front (
    .clk, .rst, .req, .push, .push_item, .push_ready
  );

  tce_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk, .rst, .push, .push_item, .push_ready, .head_valid, .head, .pop
  );

  tce_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_back (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .head_valid, .head, .pop, .rsp
  );

endmodule

/* hdl/tce_front.sv */
// Front stage that accepts commands and decodes them into internal items.
`timescale 1ns / 1ps
module tce_front import tce_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  tce_req_if.sink req,
  output logic   push,
  output item_t  push_item,
  input  logic   push_ready
);

  logic  valid;
  item_t item;
  item_t item_next;

  assign req.ready = !valid || push_ready;
  assign push      = valid;
  assign push_item = item;

  always_comb begin
    item_next.ch    = req.ch;
    item_next.attr  = req.attr;
    item_next.col   = req.col;
    item_next.row   = req.row;
    item_next.shift = req.shift;
    item_next.full  = 1'b0;
    case (req.cmd)
      CMD_PUT_CHAR:  item_next.op = OP_PUT_CHAR;
      CMD_PUT_CELL:  begin
        item_next.op = OP_PUT_CELL;
        item_next.full = 1'b1;
      end
      CMD_SET_CUR:   item_next.op = OP_SET_CUR;
      CMD_CLR_SCR_C: item_next.op = OP_CLR_SCR;
      CMD_CLR_SCR_F: begin
        item_next.op = OP_CLR_SCR;
        item_next.full = 1'b1;
      end
      CMD_CLR_LN_C:  item_next.op = OP_CLR_LINE;
      CMD_CLR_LN_F:  begin
        item_next.op = OP_CLR_LINE;
        item_next.full = 1'b1;
      end
      CMD_SCROLL:    item_next.op = OP_SCROLL;
      CMD_READ:      item_next.op = OP_READ;
      CMD_NEWLINE:   item_next.op = OP_NEWLINE;
      CMD_SKIP:      item_next.op = OP_SKIP;
      default:       item_next.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (req.ready) begin
      valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      item <= item_next;
    end
  end

endmodule

/* hdl/tce_fifo.sv */
// Short queue of decoded items between the front and back stages.
`timescale 1ns / 1ps
module tce_fifo import tce_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  push_ready,
  output logic  head_valid,
  output item_t head,
  input  logic  pop
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  item_t         slots [DEPTH];
  logic [IW-1:0] wp;
  logic [IW-1:0] rp;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = count != CW'(DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rp];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == IW'(DEPTH - 1)) ? '0 : wp + IW'(1);
      end
      if (do_pop) begin
        rp <= (rp == IW'(DEPTH - 1)) ? '0 : rp + IW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
    if (do_push) begin
      slots[wp] <= push_item;
    end
  end

endmodule

/* hdl/tce_back.sv */
// Back stage holding the screen memory, the cursor and the walk sequencer.
`timescale 1ns / 1ps
module tce_back import tce_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  head_valid,
  input  item_t                 head,
  output logic                  pop,
  tce_rsp_if.source             rsp
);

`include "text_console_engine_unit_macros.svh"

  localparam int CELLS = MAX_COLS * MAX_ROWS;
  localparam int XW    = $clog2(MAX_COLS);
  localparam int YW    = $clog2(MAX_ROWS);
  localparam int CNW   = $clog2(MAX_COLS + 1);
  localparam int RNW   = $clog2(MAX_ROWS + 1);
  localparam int AW    = $clog2(CELLS);
  localparam int TW    = $clog2(CELLS + 1);

  logic [15:0] mem [CELLS];
  logic [15:0] rdata;
  logic        we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [15:0] wdata;

  back_state_t state, state_next;

  logic [XW-1:0]  cx, cx_next;
  logic [YW-1:0]  cy, cy_next;
  logic [CNW-1:0] cols_eff, cols_eff_next;
  logic [RNW-1:0] rows_eff, rows_eff_next;
  logic [TW-1:0]  total;
  logic [AW-1:0]  w_rd, w_rd_next, w_wr, w_wr_next;
  logic [TW-1:0]  w_cnt, w_cnt_next;
  logic           w_dn, w_dn_next;
  walk_mode_t     w_mode, w_mode_next;
  logic [7:0]     w_ch, w_ch_next, w_attr, w_attr_next;
  logic           p_val, p_val_next;
  logic [AW-1:0]  p_wr, p_wr_next;
  logic           pend_scroll, pend_scroll_next, pend_fill, pend_fill_next;
  logic [7:0]     r_char, r_char_next, r_attr, r_attr_next;
  logic           r_ok, r_ok_next;
  logic           o_valid, o_valid_next;
  logic [7:0]     o_char, o_attr;
  logic           o_ok;
  logic [6:0]     o_col;
  logic [4:0]     o_row;
  logic [11:0]    o_off;

  logic           launch;
  logic           walk_done;
  logic           load_out;
  logic [TW-1:0]  cur_addr;
  logic           adv_wrap;
  logic           nl_bottom;
  logic           rd_in;
  logic           ln_in;
  logic [6:0]     mag;
  logic           scr_ok;
  logic [TW-1:0]  scr_span;
  logic [TW-1:0]  row_base;
  logic [8:0]     cn;
  logic [6:0]     rn;

  assign launch    = (state == ST_IDLE) && head_valid;
  assign pop       = launch;
  assign walk_done = (state == ST_WALK) && (w_cnt == '0) && !p_val;
  assign load_out  = (state == ST_RESP) && (!o_valid || rsp.ready);
  assign cur_addr  = TW'(cy) * TW'(cols_eff) + TW'(cx);
  assign adv_wrap  = (CNW'(cx) + CNW'(1)) >= cols_eff;
  assign nl_bottom = (RNW'(cy) + RNW'(1)) >= rows_eff;
  assign row_base  = TW'(head.row[5:0]) * TW'(cols_eff);
  assign rd_in     = !head.col[8] && !head.row[6]
                     && (10'(head.col[7:0]) < 10'(cols_eff))
                     && (8'(head.row[5:0]) < 8'(rows_eff));
  assign ln_in     = !head.row[6] && (8'(head.row[5:0]) < 8'(rows_eff));
  assign mag       = head.shift[6] ? 7'(-head.shift) : 7'(head.shift);
  assign scr_ok    = (mag != '0) && (8'(mag) < 8'(rows_eff));
  assign scr_span  = TW'(mag) * TW'(cols_eff);
  assign cn        = {1'b0, cfg_data[7:0]};
  assign rn        = {1'b0, cfg_data[5:0]};

  always_comb begin
    we    = p_val;
    waddr = p_wr;
    raddr = (state == ST_WALK) ? w_rd : AW'(row_base + TW'(head.col[7:0]));
    case (w_mode)
      WM_COPY:      wdata = rdata;
      WM_FILL_CHAR: wdata = {rdata[15:8], w_ch};
      WM_FILL_CELL: wdata = {w_attr, w_ch};
      default:      wdata = rdata;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (launch) begin
          state_next = (head.op == OP_READ) ? ST_READ : ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_done && !pend_scroll && !pend_fill) begin
          state_next = ST_RESP;
        end
      end
      ST_READ: state_next = ST_RESP;
      ST_RESP: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cx_next          = cx;
    cy_next          = cy;
    cols_eff_next    = cols_eff;
    rows_eff_next    = rows_eff;
    w_rd_next        = w_rd;
    w_wr_next        = w_wr;
    w_cnt_next       = w_cnt;
    w_dn_next        = w_dn;
    w_mode_next      = w_mode;
    w_ch_next        = w_ch;
    w_attr_next      = w_attr;
    p_val_next       = 1'b0;
    p_wr_next        = p_wr;
    pend_scroll_next = pend_scroll;
    pend_fill_next   = pend_fill;
    r_char_next      = r_char;
    r_attr_next      = r_attr;
    r_ok_next        = r_ok;

    if (cfg_we) begin
      if (cfg_index == REG_COLS) begin
        cols_eff_next = (cn == '0) ? CNW'(1)
                      : (cn > 9'(MAX_COLS)) ? CNW'(MAX_COLS) : CNW'(cn);
      end else if (cfg_index == REG_ROWS) begin
        rows_eff_next = (rn == '0) ? RNW'(1)
                      : (rn > 7'(MAX_ROWS)) ? RNW'(MAX_ROWS) : RNW'(rn);
      end
      if (CNW'(cx) >= cols_eff_next) begin
        cx_next = XW'(cols_eff_next - CNW'(1));
      end
      if (RNW'(cy) >= rows_eff_next) begin
        cy_next = YW'(rows_eff_next - RNW'(1));
      end
    end

    if (state == ST_WALK && w_cnt != '0) begin
      p_val_next = 1'b1;
      p_wr_next  = w_wr;
      w_rd_next  = w_dn ? w_rd - AW'(1) : w_rd + AW'(1);
      w_wr_next  = w_dn ? w_wr - AW'(1) : w_wr + AW'(1);
      w_cnt_next = w_cnt - TW'(1);
    end

    if (walk_done) begin
      if (pend_scroll) begin
        pend_scroll_next = 1'b0;
        w_rd_next   = AW'(cols_eff);
        w_wr_next   = '0;
        w_cnt_next  = total - TW'(cols_eff);
        w_dn_next   = 1'b0;
        w_mode_next = WM_COPY;
      end else if (pend_fill) begin
        pend_fill_next = 1'b0;
        w_rd_next   = AW'(total - TW'(cols_eff));
        w_wr_next   = AW'(total - TW'(cols_eff));
        w_cnt_next  = TW'(cols_eff);
        w_dn_next   = 1'b0;
        w_mode_next = WM_FILL_CHAR;
        w_ch_next   = '0;
      end
    end

    if (state == ST_READ) begin
      r_char_next = r_ok ? rdata[7:0] : '0;
      r_attr_next = r_ok ? rdata[15:8] : '0;
    end

    if (launch) begin
      r_char_next = '0;
      r_attr_next = '0;
      r_ok_next   = 1'b0;
      w_cnt_next  = '0;
      w_dn_next   = 1'b0;
      w_ch_next   = head.ch;
      w_attr_next = head.attr;
      w_mode_next = head.full ? WM_FILL_CELL : WM_FILL_CHAR;
      w_rd_next   = AW'(cur_addr);
      w_wr_next   = AW'(cur_addr);
      case (head.op)
        OP_PUT_CHAR, OP_PUT_CELL, OP_SKIP, OP_NEWLINE: begin
          if (head.op == OP_PUT_CHAR || head.op == OP_PUT_CELL) begin
            w_cnt_next = TW'(1);
          end
          if (head.op == OP_NEWLINE || adv_wrap) begin
            cx_next = '0;
            if (nl_bottom) begin
              cy_next          = YW'(rows_eff - RNW'(1));
              pend_scroll_next = 1'b1;
              pend_fill_next   = 1'b1;
            end else begin
              cy_next = cy + YW'(1);
            end
          end else begin
            cx_next = cx + XW'(1);
          end
        end
        OP_SET_CUR: begin
          cx_next = head.col[8] ? '0
                  : (10'(head.col[7:0]) >= 10'(cols_eff)) ? XW'(cols_eff - CNW'(1))
                  : XW'(head.col[7:0]);
          cy_next = head.row[6] ? '0
                  : (8'(head.row[5:0]) >= 8'(rows_eff)) ? YW'(rows_eff - RNW'(1))
                  : YW'(head.row[5:0]);
        end
        OP_CLR_SCR: begin
          w_rd_next  = '0;
          w_wr_next  = '0;
          w_cnt_next = total;
        end
        OP_CLR_LINE: begin
          w_rd_next  = AW'(row_base);
          w_wr_next  = AW'(row_base);
          w_cnt_next = ln_in ? TW'(cols_eff) : '0;
        end
        OP_SCROLL: begin
          w_mode_next = WM_COPY;
          w_cnt_next  = scr_ok ? total - scr_span : '0;
          if (head.shift[6]) begin
            w_dn_next = 1'b1;
            w_wr_next = AW'(total - TW'(1));
            w_rd_next = AW'(total - TW'(1) - scr_span);
          end else begin
            w_wr_next = '0;
            w_rd_next = AW'(scr_span);
          end
        end
        OP_READ: r_ok_next = rd_in;
        default: ;
      endcase
    end
  end

  assign o_valid_next = load_out || (o_valid && !rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cx          <= '0;
      cy          <= '0;
      cols_eff    <= (80 > MAX_COLS) ? CNW'(MAX_COLS) : CNW'(80);
      rows_eff    <= (25 > MAX_ROWS) ? RNW'(MAX_ROWS) : RNW'(25);
      w_cnt       <= '0;
      p_val       <= 1'b0;
      pend_scroll <= 1'b0;
      pend_fill   <= 1'b0;
      o_valid     <= 1'b0;
    end else begin
      state       <= state_next;
      cx          <= cx_next;
      cy          <= cy_next;
      cols_eff    <= cols_eff_next;
      rows_eff    <= rows_eff_next;
      w_cnt       <= w_cnt_next;
      p_val       <= p_val_next;
      pend_scroll <= pend_scroll_next;
      pend_fill   <= pend_fill_next;
      o_valid     <= o_valid_next;
    end
    total  <= TW'(cols_eff) * TW'(rows_eff);
    w_rd   <= w_rd_next;
    w_wr   <= w_wr_next;
    w_dn   <= w_dn_next;
    w_mode <= w_mode_next;
    w_ch   <= w_ch_next;
    w_attr <= w_attr_next;
    p_wr   <= p_wr_next;
    r_char <= r_char_next;
    r_attr <= r_attr_next;
    r_ok   <= r_ok_next;
    if (load_out) begin
      o_char <= r_char;
      o_attr <= r_attr;
      o_ok   <= r_ok;
      o_col  <= 7'(cx);
      o_row  <= 5'(cy);
      o_off  <= 12'(cur_addr);
    end
  end

  assign rsp.valid      = o_valid;
  assign rsp.cell_char  = o_char;
  assign rsp.cell_attr  = o_attr;
  assign rsp.cell_ok    = o_ok;
  assign rsp.cur_col    = o_col;
  assign rsp.cur_row    = o_row;
  assign rsp.cur_offset = o_off;

  `TCE_ASSERT_NOW(a_cursor_inside, 1'b1,
    (CNW'(cx) < cols_eff) && (RNW'(cy) < rows_eff), "cursor left the screen")
  `TCE_ASSERT_NOW(a_write_in_walk, we, state == ST_WALK, "memory write outside a walk")
  `TCE_ASSERT_NEXT(a_pop_starts_work, pop,
    state == ST_WALK || state == ST_READ, "popped item did not start work")
  `TCE_ASSERT_NOW(a_resp_needs_idle_pend, state == ST_RESP,
    !pend_scroll && !pend_fill && !p_val, "response before walk finished")

endmodule

/* verif/tb_text_console_engine_unit.sv */
// Self-checking testbench of the text console engine with a cursor and screen predictor.
`timescale 1ns / 1ps
module tb_text_console_engine_unit;
  import tce_pkg::*;

  typedef struct {
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic        cell_ok;
    logic [6:0]  cur_col;
    logic [4:0]  cur_row;
    logic [11:0] cur_offset;
  } cursor_report_t;

  class console_scoreboard;
    logic [15:0]    cells [DEF_MAX_COLS*DEF_MAX_ROWS];
    int             cur_x, cur_y, cols_reg, rows_reg;
    cursor_report_t owed [$];
    int             errors, reports;

    function new();
      foreach (cells[i]) cells[i] = '0;
      cur_x = 0;
      cur_y = 0;
      cols_reg = 80;
      rows_reg = 25;
      errors = 0;
      reports = 0;
    endfunction

    function int width_now();
      if (cols_reg == 0) return 1;
      return cols_reg > DEF_MAX_COLS ? DEF_MAX_COLS : cols_reg;
    endfunction

    function int height_now();
      if (rows_reg == 0) return 1;
      return rows_reg > DEF_MAX_ROWS ? DEF_MAX_ROWS : rows_reg;
    endfunction

    function void clamp_cursor();
      if (cur_x >= width_now()) cur_x = width_now() - 1;
      if (cur_y >= height_now()) cur_y = height_now() - 1;
    endfunction

    function void move_lines(int n);
      int w, h, d, total;
      w = width_now();
      h = height_now();
      total = w * h;
      if (n > 0 && n < h) begin
        d = n * w;
        for (int i = 0; i + d < total; i++) cells[i] = cells[i + d];
      end else if (n < 0 && -n < h) begin
        d = -n * w;
        for (int i = total; i > d; i--) cells[i - 1] = cells[i - 1 - d];
      end
    endfunction

    function void fill_line(int y, logic [7:0] c, logic [7:0] a, bit full);
      int k;
      for (int x = 0; x < width_now(); x++) begin
        k = y * width_now() + x;
        cells[k] = full ? {a, c} : {cells[k][15:8], c};
      end
    endfunction

    function void line_feed();
      cur_x = 0;
      if (cur_y + 1 >= height_now()) begin
        move_lines(1);
        cur_y = height_now() - 1;
        fill_line(cur_y, 8'h00, 8'h00, 1'b0);
      end else begin
        cur_y++;
      end
    endfunction

    function void step_cursor();
      if (cur_x + 1 >= width_now()) line_feed();
      else cur_x++;
    endfunction

    function void note_config(int idx, logic [7:0] val);
      if (idx == REG_COLS) cols_reg = val;
      else rows_reg = val & 8'h3f;
      clamp_cursor();
    endfunction

    function void note_command(logic [3:0] cmd, logic [7:0] c, logic [7:0] a,
                               int px, int py, int sh);
      cursor_report_t r;
      int w, h, k;
      w = width_now();
      h = height_now();
      r.cell_char = '0;
      r.cell_attr = '0;
      r.cell_ok = 1'b0;
      clamp_cursor();
      k = cur_y * w + cur_x;
      case (cmd)
        CMD_PUT_CHAR: begin
          cells[k] = {cells[k][15:8], c};
          step_cursor();
        end
        CMD_PUT_CELL: begin
          cells[k] = {a, c};
          step_cursor();
        end
        CMD_SET_CUR: begin
          cur_x = px < 0 ? 0 : (px >= w ? w - 1 : px);
          cur_y = py < 0 ? 0 : (py >= h ? h - 1 : py);
        end
        CMD_CLR_SCR_C, CMD_CLR_SCR_F:
          for (int y = 0; y < h; y++) fill_line(y, c, a, cmd == CMD_CLR_SCR_F);
        CMD_CLR_LN_C, CMD_CLR_LN_F:
          if (py >= 0 && py < h) fill_line(py, c, a, cmd == CMD_CLR_LN_F);
        CMD_SCROLL: move_lines(sh);
        CMD_READ:
          if (px >= 0 && py >= 0 && px < w && py < h) begin
            {r.cell_attr, r.cell_char} = cells[py * w + px];
            r.cell_ok = 1'b1;
          end
        CMD_NEWLINE: line_feed();
        CMD_SKIP: step_cursor();
        default: ;
      endcase
      r.cur_col = 7'(cur_x);
      r.cur_row = 5'(cur_y);
      r.cur_offset = 12'(cur_y * w + cur_x);
      owed.push_back(r);
    endfunction

    task report(string what, int got, int want);
      $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
      errors++;
    endtask

    task check_report(cursor_report_t got);
      cursor_report_t want;
      reports++;
      if (owed.size() == 0) begin
        report("response with nothing outstanding, offset", got.cur_offset, 0);
      end else begin
        want = owed.pop_front();
        if (got.cell_char !== want.cell_char) report("cell_char", got.cell_char, want.cell_char);
        if (got.cell_attr !== want.cell_attr) report("cell_attr", got.cell_attr, want.cell_attr);
        if (got.cell_ok !== want.cell_ok) report("cell_ok", got.cell_ok, want.cell_ok);
        if (got.cur_col !== want.cur_col) report("cur_col", got.cur_col, want.cur_col);
        if (got.cur_row !== want.cur_row) report("cur_row", got.cur_row, want.cur_row);
        if (got.cur_offset !== want.cur_offset)
          report("cur_offset", got.cur_offset, want.cur_offset);
      end
    endtask
  endclass

  localparam int STALL_LIMIT = 60000;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tce_req_if req_ch ();
  tce_rsp_if rsp_ch ();

  text_console_engine_unit u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req_ch), .rsp(rsp_ch)
  );

  console_scoreboard sb = new();
  int send_idle_pct;
  int recv_idle_pct;
  int commands_sent;
  int stall_cycles;

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rsp_ch.valid && rsp_ch.ready && !rst)
      sb.check_report('{rsp_ch.cell_char, rsp_ch.cell_attr, rsp_ch.cell_ok,
                        rsp_ch.cur_col, rsp_ch.cur_row, rsp_ch.cur_offset});
    if (rst) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= $urandom_range(0, 99) >= recv_idle_pct;
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || rst)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task send_command(logic [3:0] cmd, logic [7:0] c, logic [7:0] a,
                    logic signed [8:0] px, logic signed [6:0] py, logic signed [6:0] sh);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd <= cmd;
    req_ch.ch <= c;
    req_ch.attr <= a;
    req_ch.col <= px;
    req_ch.row <= py;
    req_ch.shift <= sh;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_command(cmd, c, a, px, py, sh);
    commands_sent++;
  endtask

  task drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
  endtask

  task write_geometry(logic [7:0] c, logic [7:0] r);
    drain();
    repeat (12) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_COLS;
    cfg_data <= c;
    @(posedge clk);
    sb.note_config(REG_COLS, c);
    cfg_index <= REG_ROWS;
    cfg_data <= r;
    @(posedge clk);
    sb.note_config(REG_ROWS, r);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task random_commands(int count);
    int w, h, pick, pause_at;
    logic [3:0] cmd;
    logic signed [8:0] px;
    logic signed [6:0] py, sh;
    w = sb.width_now();
    h = sb.height_now();
    pause_at = $urandom_range(1, count - 1);
    for (int n = 0; n < count; n++) begin
      if (n == pause_at) drain();
      pick = $urandom_range(0, 99);
      if (pick < 30) cmd = CMD_PUT_CHAR;
      else if (pick < 52) cmd = CMD_PUT_CELL;
      else if (pick < 62) cmd = CMD_SET_CUR;
      else if (pick < 76) cmd = CMD_READ;
      else if (pick < 81) cmd = CMD_NEWLINE;
      else if (pick < 86) cmd = CMD_SKIP;
      else if (pick < 91) cmd = $urandom_range(0, 1) ? CMD_CLR_LN_C : CMD_CLR_LN_F;
      else if (pick < 95) cmd = CMD_SCROLL;
      else if (pick < 98) cmd = $urandom_range(0, 1) ? CMD_CLR_SCR_C : CMD_CLR_SCR_F;
      else cmd = 4'($urandom_range(11, 15));
      if (w * h > 1024 && (cmd == CMD_SCROLL || cmd == CMD_CLR_SCR_C || cmd == CMD_CLR_SCR_F)
          && $urandom_range(0, 3) != 0)
        cmd = CMD_READ;
      px = $urandom_range(0, 3) == 0 ? 9'($urandom) : 9'($urandom_range(0, w));
      py = $urandom_range(0, 3) == 0 ? 7'($urandom) : 7'($urandom_range(0, h));
      sh = $urandom_range(0, 2) == 0 ? 7'($urandom) : 7'($urandom_range(0, 2 * h) - h);
      send_command(cmd, 8'($urandom), 8'($urandom), px, py, sh);
    end
  endtask

  initial begin
    logic [7:0] geo_cols [10];
    logic [7:0] geo_rows [10];
    geo_cols = '{80, 1, 255, 0, 8, 5, 128, 3, 17, 200};
    geo_rows = '{25, 1, 63, 0, 4, 3, 32, 40, 9, 8'hc7};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.cmd = '0;
    req_ch.ch = '0;
    req_ch.attr = '0;
    req_ch.col = '0;
    req_ch.row = '0;
    req_ch.shift = '0;
    send_idle_pct = 21;
    recv_idle_pct = 53;
    commands_sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed commands on the reset geometry of 80 by 25.
    send_command(CMD_CLR_SCR_F, 8'h20, 8'h07, 0, 0, 0);
    send_command(CMD_PUT_CHAR, 8'h00, 8'h00, 0, 0, 0);
    send_command(CMD_PUT_CELL, 8'hff, 8'hff, 0, 0, 0);
    send_command(CMD_PUT_CELL, 8'h00, 8'h00, 0, 0, 0);
    send_command(CMD_SET_CUR, 0, 0, -256, -64, 0);
    send_command(CMD_SET_CUR, 0, 0, 255, 63, 0);
    send_command(CMD_PUT_CELL, 8'h41, 8'h1e, 0, 0, 0);
    send_command(CMD_READ, 0, 0, -1, 0, 0);
    send_command(CMD_READ, 0, 0, 80, 0, 0);
    send_command(CMD_READ, 0, 0, 0, 25, 0);
    send_command(CMD_READ, 0, 0, 0, 0, 0);
    send_command(CMD_READ, 0, 0, 79, 24, 0);
    send_command(CMD_CLR_LN_C, 8'h2e, 0, 0, -1, 0);
    send_command(CMD_CLR_LN_C, 8'h2e, 0, 0, 24, 0);
    send_command(CMD_CLR_LN_F, 8'h2d, 8'h70, 0, 25, 0);
    send_command(CMD_CLR_LN_F, 8'h2d, 8'h70, 0, 0, 0);
    send_command(CMD_SCROLL, 0, 0, 0, 0, 0);
    send_command(CMD_SCROLL, 0, 0, 0, 0, 25);
    send_command(CMD_SCROLL, 0, 0, 0, 0, -25);
    send_command(CMD_SCROLL, 0, 0, 0, 0, 1);
    send_command(CMD_SCROLL, 0, 0, 0, 0, -1);
    send_command(CMD_SCROLL, 0, 0, 0, 0, -64);
    send_command(CMD_NEWLINE, 0, 0, 0, 0, 0);
    send_command(CMD_SKIP, 0, 0, 0, 0, 0);
    send_command(4'd15, 8'hff, 8'hff, -1, -1, -1);
    send_command(CMD_CLR_SCR_C, 8'h23, 0, 0, 0, 0);
    random_commands(70);

    for (int p = 1; p < 10; p++) begin
      if (p == 4) begin
        send_idle_pct = 53;
        recv_idle_pct = 21;
      end else if (p == 7) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_geometry(geo_cols[p], geo_rows[p]);
      send_command(CMD_CLR_SCR_F, 8'($urandom), 8'($urandom), 0, 0, 0);
      random_commands(95);
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Ran %0d commands over ten screen geometries, %0d responses checked.",
             commands_sent, sb.reports);
    $display("Covered wraps, bottom scrolls, clamped cursors, reads outside and idle phases.");
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+hdl
hdl/tce_pkg.sv
hdl/tce_req_if.sv
hdl/tce_rsp_if.sv
hdl/tce_front.sv
hdl/tce_fifo.sv
hdl/tce_back.sv
hdl/text_console_engine_unit.sv
verif/tb_text_console_engine_unit.sv
